// ----- rtl/pump_ramp_controller_core_assert.svh -----
// Assertion macros for the pump ramp controller RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef PUMP_RAMP_CONTROLLER_CORE_ASSERT_SVH
`define PUMP_RAMP_CONTROLLER_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PRC_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pump ramp controller: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define PRC_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pump ramp controller: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define PRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pump ramp controller: next-cycle check violated");

`endif

// ----- rtl/prc_pkg.sv -----
// Shared types and constants for the pump ramp controller.
// No dependencies; used by all RTL modules of the block.
`timescale 1ns / 1ps

package prc_pkg;

	localparam int STEP_W      = 10;
	localparam int CFG_LEVEL_W = 12;
	localparam int TICK_W      = 6;
	localparam int SEC_W       = 4;
	localparam int TARGET_W    = 10;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 3;

	// Event codes carried in the input tuser field.
	typedef enum logic [2:0] {
		CMD_START    = 3'd0,
		CMD_VALVE    = 3'd1,
		CMD_ALL_STOP = 3'd2,
		CMD_TICK     = 3'd3,
		CMD_CLICK    = 3'd4
	} cmd_t;

	// Direction codes of a start command.
	localparam logic [1:0] DIR_FORWARD  = 2'd0;
	localparam logic [1:0] DIR_BACKWARD = 2'd1;
	localparam logic [1:0] DIR_NEUTRAL  = 2'd2;
	localparam logic [1:0] DIR_KEEP     = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_LEVEL  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKWARD_LEVEL = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_NEUTRAL_LEVEL  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TICK_LIMIT     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SECONDS_LIMIT  = 3'd5;

	// Register reset values.
	localparam logic [STEP_W-1:0]      STEP_SIZE_RST      = 10'd100;
	localparam logic [CFG_LEVEL_W-1:0] FORWARD_LEVEL_RST  = 12'd4000;
	localparam logic [CFG_LEVEL_W-1:0] BACKWARD_LEVEL_RST = 12'd2000;
	localparam logic [CFG_LEVEL_W-1:0] NEUTRAL_LEVEL_RST  = 12'd3000;
	localparam logic [TICK_W-1:0]      TICK_LIMIT_RST     = 6'd30;
	localparam logic [SEC_W-1:0]       SECONDS_LIMIT_RST  = 4'd1;

	// Drive and target level after reset.
	localparam int LEVEL_RESET = 3000;

	typedef struct packed {
		cmd_t                command;
		logic                ramp_request;
		logic [1:0]          direction;
		logic [TARGET_W-1:0] click_target;
		logic                valve_close;
	} item_t;

	typedef struct packed {
		logic [STEP_W-1:0]      step_size;
		logic [CFG_LEVEL_W-1:0] forward_level;
		logic [CFG_LEVEL_W-1:0] backward_level;
		logic [CFG_LEVEL_W-1:0] neutral_level;
		logic [TICK_W-1:0]      tick_limit;
		logic [SEC_W-1:0]       seconds_limit;
	} cfg_t;

	typedef struct packed {
		logic running;
		logic ramping;
		logic stopped;
		logic valve;
		logic led;
	} status_t;

endpackage

// ----- rtl/prc_cfg_regs.sv -----
// Configuration register file of the pump ramp controller.
// Depends on prc_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps

module prc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [prc_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [prc_pkg::CFG_DATA_W-1:0]   wr_data,
	output prc_pkg::cfg_t                    cfg
);

	prc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size      <= prc_pkg::STEP_SIZE_RST;
			cfg_q.forward_level  <= prc_pkg::FORWARD_LEVEL_RST;
			cfg_q.backward_level <= prc_pkg::BACKWARD_LEVEL_RST;
			cfg_q.neutral_level  <= prc_pkg::NEUTRAL_LEVEL_RST;
			cfg_q.tick_limit     <= prc_pkg::TICK_LIMIT_RST;
			cfg_q.seconds_limit  <= prc_pkg::SECONDS_LIMIT_RST;
		end else if (wr_en) begin
			// Writes to indexes beyond the register list are dropped.
			unique case (wr_index)
				prc_pkg::REG_STEP_SIZE: begin
					cfg_q.step_size <= wr_data[prc_pkg::STEP_W-1:0];
				end
				prc_pkg::REG_FORWARD_LEVEL: begin
					cfg_q.forward_level <= wr_data[prc_pkg::CFG_LEVEL_W-1:0];
				end
				prc_pkg::REG_BACKWARD_LEVEL: begin
					cfg_q.backward_level <= wr_data[prc_pkg::CFG_LEVEL_W-1:0];
				end
				prc_pkg::REG_NEUTRAL_LEVEL: begin
					cfg_q.neutral_level <= wr_data[prc_pkg::CFG_LEVEL_W-1:0];
				end
				prc_pkg::REG_TICK_LIMIT: begin
					cfg_q.tick_limit <= wr_data[prc_pkg::TICK_W-1:0];
				end
				prc_pkg::REG_SECONDS_LIMIT: begin
					cfg_q.seconds_limit <= wr_data[prc_pkg::SEC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/prc_ctrl.sv -----
// Control state of the pump ramp controller and its per-item update logic.
// Depends on prc_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`include "pump_ramp_controller_core_assert.svh"

module prc_ctrl #(
	parameter int LEVEL_WIDTH = 12,
	parameter int CLICK_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd_en,
	input  prc_pkg::item_t         item,
	input  prc_pkg::cfg_t          cfg,
	output logic [LEVEL_WIDTH-1:0] drive_level,
	output logic [CLICK_WIDTH-1:0] clicks_seen,
	output prc_pkg::status_t       status
);

	localparam int STEP_CMP_W  = (LEVEL_WIDTH > prc_pkg::STEP_W) ? LEVEL_WIDTH : prc_pkg::STEP_W;
	localparam int CLICK_CMP_W = (CLICK_WIDTH > prc_pkg::TARGET_W) ?
		CLICK_WIDTH : prc_pkg::TARGET_W;

	logic [LEVEL_WIDTH-1:0]       drive_level_q, target_level_q;
	logic [prc_pkg::TARGET_W-1:0] click_limit_q;
	logic [CLICK_WIDTH-1:0]       clicks_seen_q;
	logic [prc_pkg::TICK_W-1:0]   tick_prescale_q;
	logic [prc_pkg::SEC_W-1:0]    seconds_count_q;
	logic step_pending_q, ramping_q, running_q, stop_latched_q, valve_state_q, led_state_q;

	logic [LEVEL_WIDTH-1:0]       drive_d, target_d, gap;
	logic [prc_pkg::TARGET_W-1:0] limit_d;
	logic [CLICK_WIDTH-1:0]       clicks_d;
	logic [prc_pkg::TICK_W-1:0]   prescale_d;
	logic [prc_pkg::SEC_W-1:0]    seconds_d;
	logic [prc_pkg::TICK_W:0]     prescale_inc;
	logic [prc_pkg::SEC_W:0]      seconds_inc;
	logic step_d, ramp_d, run_d, stop_d, valve_d, led_d;

	always_comb begin
		drive_d      = drive_level_q;
		target_d     = target_level_q;
		limit_d      = click_limit_q;
		clicks_d     = clicks_seen_q;
		prescale_d   = tick_prescale_q;
		seconds_d    = seconds_count_q;
		step_d       = step_pending_q;
		ramp_d       = ramping_q;
		run_d        = running_q;
		stop_d       = stop_latched_q;
		valve_d      = valve_state_q;
		led_d        = led_state_q;
		gap          = '0;
		prescale_inc = {1'b0, tick_prescale_q} + 1'b1;
		seconds_inc  = '0;

		// Apply the event itself.
		unique case (item.command)
			prc_pkg::CMD_START: begin
				ramp_d   = item.ramp_request;
				run_d    = 1'b1;
				clicks_d = '0;
				stop_d   = 1'b0;
				limit_d  = item.click_target;
				case (item.direction)
					prc_pkg::DIR_FORWARD:  target_d = LEVEL_WIDTH'(cfg.forward_level);
					prc_pkg::DIR_BACKWARD: target_d = LEVEL_WIDTH'(cfg.backward_level);
					prc_pkg::DIR_NEUTRAL:  target_d = LEVEL_WIDTH'(cfg.neutral_level);
					default:               target_d = target_level_q;
				endcase
			end
			prc_pkg::CMD_VALVE: begin
				valve_d = item.valve_close;
			end
			prc_pkg::CMD_ALL_STOP: begin
				stop_d    = 1'b1;
				run_d     = 1'b0;
				seconds_d = '0;
			end
			prc_pkg::CMD_TICK: begin
				if (running_q) begin
					led_d = ~led_state_q;
					if (prescale_inc > {1'b0, cfg.tick_limit}) begin
						prescale_d  = '0;
						seconds_inc = {1'b0, seconds_count_q} + 1'b1;
					end else begin
						prescale_d  = prescale_inc[prc_pkg::TICK_W-1:0];
						seconds_inc = {1'b0, seconds_count_q};
					end
					// The seconds count is checked even when it did not advance.
					if (seconds_inc > {1'b0, cfg.seconds_limit}) begin
						step_d    = 1'b1;
						seconds_d = '0;
					end else begin
						seconds_d = seconds_inc[prc_pkg::SEC_W-1:0];
					end
				end
			end
			prc_pkg::CMD_CLICK: begin
				if (clicks_seen_q != {CLICK_WIDTH{1'b1}}) begin
					clicks_d = clicks_seen_q + 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Control update, run once after every event.
		if (!stop_d) begin
			if (run_d) begin
				if (!ramp_d) begin
					drive_d = target_d;
				end else if (step_d) begin
					// A step that would pass the target clamps there and ends the ramp;
					// landing exactly on it keeps the ramp flag set.
					if (drive_d < target_d) begin
						gap = target_d - drive_d;
						if (STEP_CMP_W'(cfg.step_size) > STEP_CMP_W'(gap)) begin
							drive_d = target_d;
							ramp_d  = 1'b0;
						end else begin
							drive_d = drive_d + LEVEL_WIDTH'(cfg.step_size);
						end
					end else if (drive_d > target_d) begin
						gap = drive_d - target_d;
						if (STEP_CMP_W'(cfg.step_size) > STEP_CMP_W'(gap)) begin
							drive_d = target_d;
							ramp_d  = 1'b0;
						end else begin
							drive_d = drive_d - LEVEL_WIDTH'(cfg.step_size);
						end
					end
					step_d = 1'b0;
				end
			end
			if (CLICK_CMP_W'(clicks_d) > CLICK_CMP_W'(limit_d)) begin
				run_d = 1'b0;
			end
		end else begin
			led_d     = 1'b1;
			run_d     = 1'b0;
			ramp_d    = 1'b0;
			seconds_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_level_q   <= LEVEL_WIDTH'(prc_pkg::LEVEL_RESET);
			target_level_q  <= LEVEL_WIDTH'(prc_pkg::LEVEL_RESET);
			click_limit_q   <= '0;
			clicks_seen_q   <= '0;
			tick_prescale_q <= '0;
			seconds_count_q <= '0;
			step_pending_q  <= 1'b0;
			ramping_q       <= 1'b0;
			running_q       <= 1'b0;
			stop_latched_q  <= 1'b1;
			valve_state_q   <= 1'b0;
			led_state_q     <= 1'b1;
		end else if (upd_en) begin
			drive_level_q   <= drive_d;
			target_level_q  <= target_d;
			click_limit_q   <= limit_d;
			clicks_seen_q   <= clicks_d;
			tick_prescale_q <= prescale_d;
			seconds_count_q <= seconds_d;
			step_pending_q  <= step_d;
			ramping_q       <= ramp_d;
			running_q       <= run_d;
			stop_latched_q  <= stop_d;
			valve_state_q   <= valve_d;
			led_state_q     <= led_d;
		end
	end

	assign drive_level    = drive_level_q;
	assign clicks_seen    = clicks_seen_q;
	assign status.running = running_q;
	assign status.ramping = ramping_q;
	assign status.stopped = stop_latched_q;
	assign status.valve   = valve_state_q;
	assign status.led     = led_state_q;

	// An all-stop leaves neither pumping nor a ramp in force.
	`PRC_ASSERT_IMPLIES(a_stop_clears_run, stop_latched_q, !running_q && !ramping_q)
	// Pumping never stays on once the click count has passed the target.
	`PRC_ASSERT_HOLDS(a_run_within_limit,
		!running_q || (CLICK_CMP_W'(clicks_seen_q) <= CLICK_CMP_W'(click_limit_q)))
	// The visible state only moves when an item is processed.
	`PRC_ASSERT_NEXT(a_hold_without_item, !upd_en,
		$stable(drive_level_q) && $stable(clicks_seen_q) && $stable(running_q))

endmodule

// ----- rtl/pump_ramp_controller_core.sv -----
// Path: an accepted item waits in the input register until the result register can take it,
// then is processed into the control state registers, which drive m_tdata.
// Throughput: one item per cycle, set by the single registered control update per item.
// Backpressure on the result side stalls the input register, which still holds one item.
// Reset (arst_n low): registers return to their defaults, the pump is stopped with the
// drive level at neutral, the LED is on and no item or result is pending.
`timescale 1ns / 1ps

// Top level of the pump ramp controller: input register, configuration registers,
// control state and result handshake. Depends on prc_pkg, prc_cfg_regs and prc_ctrl.
module pump_ramp_controller_core #(
	parameter int LEVEL_WIDTH = 12,
	parameter int CLICK_WIDTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Input item stream.
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// s_tdata, lowest bit up: ramp_request[0], direction[2:1], click_target[12:3],
	// valve_close[13], zero padding[15:14].
	input  logic [15:0]                              s_tdata,
	// s_tuser: command[2:0].
	input  logic [2:0]                               s_tuser,
	// Result stream.
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// m_tdata, lowest bit up: pwm_level, pump_running, ramp_active, all_stopped,
	// valve_closed, status_led, click_count, then zero padding to whole bytes.
	output logic [((LEVEL_WIDTH + CLICK_WIDTH + 5 + 7) / 8) * 8 - 1:0] m_tdata,
	// Configuration write channel.
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [prc_pkg::CFG_INDEX_W-1:0]          cfg_index,
	input  logic [prc_pkg::CFG_DATA_W-1:0]           cfg_data
);

	localparam int OUT_BITS = LEVEL_WIDTH + CLICK_WIDTH + 5;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	prc_pkg::item_t   item_in, item_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;
	prc_pkg::cfg_t    cfg;
	prc_pkg::status_t status;
	logic [LEVEL_WIDTH-1:0] drive_level;
	logic [CLICK_WIDTH-1:0] clicks_seen;

	// Unpack the incoming item.
	assign item_in.command      = prc_pkg::cmd_t'(s_tuser);
	assign item_in.ramp_request = s_tdata[0];
	assign item_in.direction    = s_tdata[2:1];
	assign item_in.click_target = s_tdata[12:3];
	assign item_in.valve_close  = s_tdata[13];

	// The item in the input register is processed when the result register is free or
	// its current result is being taken in this cycle. The control state registers are
	// themselves the result register, so they only move on such a cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Configuration writes always taken; user issues only while block idle; unenforced.
	assign cfg_ready = 1'b1;

	prc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	prc_ctrl #(
		.LEVEL_WIDTH (LEVEL_WIDTH),
		.CLICK_WIDTH (CLICK_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd_en      (advance),
		.item        (item_s1),
		.cfg         (cfg),
		.drive_level (drive_level),
		.clicks_seen (clicks_seen),
		.status      (status)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({clicks_seen, status.led, status.valve, status.stopped,
		status.ramping, status.running, drive_level});

endmodule
